[rtl/tcch_pkg.sv]
// ----------------------------------------------------------------------------
// tcch_pkg
// Shared constants and types for the character class histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcch_pkg;

  localparam int CHUNK_LIMIT_DEF = 255;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int BIN_COUNT       = 26;
  localparam int BIN_ADDR_W      = $clog2(BIN_COUNT);

  localparam int TOTAL_COUNT  = 5;
  localparam int TOT_SEL_W    = $clog2(TOTAL_COUNT);
  localparam int REPORT_COUNT = TOTAL_COUNT + BIN_COUNT;
  localparam int IDX_W        = 5;
  localparam int REPORT_W     = 32;
  localparam int OUT_DATA_W   = ((IDX_W + REPORT_W + 7) / 8) * 8;

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [IDX_W-1:0] IDX_LINES    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_CHARS    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LETTERS  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_DIGITS   = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_OTHERS   = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_BIN_BASE = IDX_W'(TOTAL_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(REPORT_COUNT - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic                  en;
    logic [BIN_ADDR_W-1:0] addr;
  } bin_port_t;

endpackage

`default_nettype wire

[rtl/tcch_bin_mem.sv]
// ----------------------------------------------------------------------------
// tcch_bin_mem
// Letter bin store: one write port, one registered read port, per-entry
// valid bits so that never-written bins read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_bin_mem #(
  parameter int COUNT_WIDTH = tcch_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tcch_pkg::bin_port_t    rd,
  input  wire tcch_pkg::bin_port_t    wr,
  input  wire logic [COUNT_WIDTH-1:0] wr_data,
  output logic      [COUNT_WIDTH-1:0] rd_data
);
  import tcch_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [BIN_COUNT-1:0]   valid_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr_data;
    end
    if (rd.en) begin
      rd_data_r <= valid_r[rd.addr] ? mem[rd.addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/tcch_byte_path.sv]
// ----------------------------------------------------------------------------
// tcch_byte_path
// Chunk tracking, byte classification, total counters and the
// read-modify-write of the letter bins with write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_byte_path #(
  parameter int CHUNK_LIMIT = tcch_pkg::CHUNK_LIMIT_DEF,
  parameter int COUNT_WIDTH = tcch_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   byte_go,
  input  wire logic [7:0]             text_byte,
  input  wire logic [COUNT_WIDTH-1:0] bin_rd_data,
  output tcch_pkg::bin_port_t         bin_rd,
  output tcch_pkg::bin_port_t         bin_wr,
  output logic      [COUNT_WIDTH-1:0] bin_wr_data,
  output logic [tcch_pkg::TOTAL_COUNT-1:0][COUNT_WIDTH-1:0] totals
);
  import tcch_pkg::*;

  localparam int FILL_W = $clog2(CHUNK_LIMIT + 1);
  localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

  logic                  open_r;
  logic [FILL_W-1:0]     fill_r;
  logic                  zseen_r;
  logic [TOTAL_COUNT-1:0][COUNT_WIDTH-1:0] tot_r;

  logic                  s1_valid_r;
  logic [BIN_ADDR_W-1:0] s1_addr_r;
  logic                  byp_hit_r;
  logic [COUNT_WIDTH-1:0] byp_data_r;

  logic [FILL_W-1:0]     fill_base;
  logic [FILL_W-1:0]     fill_new;
  logic                  zero_base;
  logic                  counted;
  logic                  is_upper;
  logic                  is_lower;
  logic                  is_letter;
  logic                  is_digit;
  logic                  closes;
  logic [BIN_ADDR_W-1:0] bin_addr;
  logic                  bin_go;
  logic [COUNT_WIDTH-1:0] bin_old;

  always_comb begin
    fill_base = open_r ? fill_r : '0;
    zero_base = open_r ? zseen_r : 1'b0;
    fill_new  = fill_base + FILL_W'(1);
    counted   = (text_byte != CH_NUL) && !zero_base && (text_byte != CH_NL);
    is_upper  = (text_byte >= CH_UA) && (text_byte <= CH_UZ);
    is_lower  = (text_byte >= CH_LA) && (text_byte <= CH_LZ);
    is_letter = is_upper || is_lower;
    is_digit  = (text_byte >= CH_D0) && (text_byte <= CH_D9);
    closes    = (text_byte == CH_NL) || (fill_new >= FILL_W'(CHUNK_LIMIT));
    bin_addr  = BIN_ADDR_W'((text_byte | CASE_BIT) - CH_LA);
    bin_go    = byte_go && counted && is_letter;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      fill_r  <= '0;
      zseen_r <= 1'b0;
      tot_r   <= '0;
    end else if (byte_go) begin
      if (closes) begin
        open_r  <= 1'b0;
        fill_r  <= '0;
        zseen_r <= 1'b0;
      end else begin
        open_r  <= 1'b1;
        fill_r  <= fill_new;
        zseen_r <= zero_base || (text_byte == CH_NUL);
      end
      if (!open_r) begin
        tot_r[TOT_SEL_W'(IDX_LINES)] <= tot_r[TOT_SEL_W'(IDX_LINES)] + ONE;
      end
      if (counted) begin
        tot_r[TOT_SEL_W'(IDX_CHARS)] <= tot_r[TOT_SEL_W'(IDX_CHARS)] + ONE;
        if (is_letter) begin
          tot_r[TOT_SEL_W'(IDX_LETTERS)] <= tot_r[TOT_SEL_W'(IDX_LETTERS)] + ONE;
        end else if (is_digit) begin
          tot_r[TOT_SEL_W'(IDX_DIGITS)] <= tot_r[TOT_SEL_W'(IDX_DIGITS)] + ONE;
        end else begin
          tot_r[TOT_SEL_W'(IDX_OTHERS)] <= tot_r[TOT_SEL_W'(IDX_OTHERS)] + ONE;
        end
      end
    end
  end

  // forward the bin being written when the next read hits the same bin
  always_comb begin
    bin_old     = byp_hit_r ? byp_data_r : bin_rd_data;
    bin_wr_data = bin_old + ONE;
    bin_wr.en   = s1_valid_r;
    bin_wr.addr = s1_addr_r;
    bin_rd.en   = bin_go;
    bin_rd.addr = bin_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= bin_go;
      byp_hit_r  <= bin_go && s1_valid_r && (s1_addr_r == bin_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= bin_addr;
    byp_data_r <= bin_wr_data;
  end

  assign totals = tot_r;

endmodule

`default_nettype wire

[rtl/tcch_report_seq.sv]
// ----------------------------------------------------------------------------
// tcch_report_seq
// Report sequencer: walks the 31 counters, reads the bins through the
// shared read port and holds each result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_report_seq #(
  parameter int COUNT_WIDTH = tcch_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   out_ready,
  input  wire logic [tcch_pkg::TOTAL_COUNT-1:0][COUNT_WIDTH-1:0] totals,
  input  wire logic [COUNT_WIDTH-1:0] bin_rd_data,
  output tcch_pkg::bin_port_t         bin_rd,
  output logic                        busy,
  output logic                        out_valid,
  output logic [tcch_pkg::IDX_W-1:0]  out_idx,
  output logic [tcch_pkg::REPORT_W-1:0] out_value,
  output logic                        out_last
);
  import tcch_pkg::*;

  logic             active_r;
  logic [IDX_W-1:0] iss_idx_r;
  logic             rs_valid_r;
  logic [IDX_W-1:0] rs_idx_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [REPORT_W-1:0] out_value_r;
  logic             out_last_r;

  logic             adv;
  logic             issue;
  logic [COUNT_WIDTH-1:0] rs_value;

  always_comb begin
    adv         = !out_valid_r || out_ready;
    issue       = adv && active_r;
    bin_rd.en   = issue && (iss_idx_r >= IDX_BIN_BASE);
    bin_rd.addr = BIN_ADDR_W'(iss_idx_r - IDX_BIN_BASE);
    if (rs_idx_r < IDX_BIN_BASE) begin
      rs_value = totals[TOT_SEL_W'(rs_idx_r)];
    end else begin
      rs_value = bin_rd_data;
    end
    busy = active_r || rs_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      iss_idx_r   <= '0;
      rs_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        active_r  <= 1'b1;
        iss_idx_r <= IDX_LINES;
      end else if (issue) begin
        iss_idx_r <= iss_idx_r + IDX_W'(1);
        if (iss_idx_r == IDX_LAST) begin
          active_r <= 1'b0;
        end
      end
      if (adv) begin
        rs_valid_r  <= issue;
        out_valid_r <= rs_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rs_idx_r <= iss_idx_r;
    end
    if (adv && rs_valid_r) begin
      out_idx_r   <= rs_idx_r;
      out_value_r <= REPORT_W'(rs_value);
      out_last_r  <= (rs_idx_r == IDX_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[rtl/text_char_class_histogram.sv]
// ----------------------------------------------------------------------------
// text_char_class_histogram
// Line, character class and case-folded letter histogram counter over a
// byte stream, with a 31-beat report on an end-of-input beat.
// ----------------------------------------------------------------------------
// Data bytes are taken one per cycle with no gaps while no report runs; a
// letter's bin update is a read-modify-write on the bin memory, with the
// write forwarded to a back-to-back read of the same bin. An end-of-input
// beat starts a report of 31 result beats (lines, chars, letters, digits,
// others, bins a..z), which pass through issue, read and output registers,
// one per cycle while the sink is ready. The input is held off for the
// length of the report, since it reads the bins over the memory's single
// read port. Counters keep running across reports and wrap at their width.
// ----------------------------------------------------------------------------
`default_nettype none

module text_char_class_histogram #(
  parameter int CHUNK_LIMIT = tcch_pkg::CHUNK_LIMIT_DEF,
  parameter int COUNT_WIDTH = tcch_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,  // [7:0] text_byte
  input  wire logic                            in_tuser,  // [0] op
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [tcch_pkg::OUT_DATA_W-1:0]      out_tdata, // [4:0] report_index,
                                                          // [36:5] report_value
  output logic                                 out_tlast  // report_last
);
  import tcch_pkg::*;

  logic                   in_beat;
  logic                   byte_go;
  logic                   report_go;
  logic                   seq_busy;
  bin_port_t              byte_rd;
  bin_port_t              seq_rd;
  bin_port_t              mem_rd;
  bin_port_t              mem_wr;
  logic [COUNT_WIDTH-1:0] mem_wr_data;
  logic [COUNT_WIDTH-1:0] mem_rd_data;
  logic [TOTAL_COUNT-1:0][COUNT_WIDTH-1:0] totals;
  logic [IDX_W-1:0]       rep_idx;
  logic [REPORT_W-1:0]    rep_value;

  always_comb begin
    in_tready = !seq_busy;
    in_beat   = in_tvalid && in_tready;
    byte_go   = in_beat && (in_tuser == OP_DATA);
    report_go = in_beat && (in_tuser == OP_REPORT);
    mem_rd    = seq_rd.en ? seq_rd : byte_rd;
    out_tdata = OUT_DATA_W'({rep_value, rep_idx});
  end

  tcch_byte_path #(
    .CHUNK_LIMIT (CHUNK_LIMIT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_byte_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_go     (byte_go),
    .text_byte   (in_tdata),
    .bin_rd_data (mem_rd_data),
    .bin_rd      (byte_rd),
    .bin_wr      (mem_wr),
    .bin_wr_data (mem_wr_data),
    .totals      (totals)
  );

  tcch_bin_mem #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bin_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (mem_rd),
    .wr      (mem_wr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  tcch_report_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_report_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (report_go),
    .out_ready   (out_tready),
    .totals      (totals),
    .bin_rd_data (mem_rd_data),
    .bin_rd      (seq_rd),
    .busy        (seq_busy),
    .out_valid   (out_tvalid),
    .out_idx     (rep_idx),
    .out_value   (rep_value),
    .out_last    (out_tlast)
  );

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[IDX_W-1:0] == IDX_LAST)
    else $error("last report beat carries wrong index");

  a_report_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_REPORT) |=> !in_tready)
    else $error("input taken while report starts");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[IDX_W-1:0] == IDX_W'($past(out_tdata[IDX_W-1:0]) + 1)))
    else $error("report beats not contiguous");

  a_no_bin_clash: assert property (@(posedge clk) disable iff (!rst_n)
    seq_rd.en |-> !byte_rd.en && !mem_wr.en)
    else $error("report read overlaps bin update");

endmodule

`default_nettype wire
